// File: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the SHA-256 byte-stream hash block.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int BLK_BITS  = 512;
  localparam int BLK_BYTES = 64;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  // last byte position at which the length still fits after the 0x80 marker
  localparam logic [5:0] PAD_LIMIT = 6'd55;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [7:0] PAD_MARK  = 8'h80;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [63:0] digest_part0;
    logic [63:0] digest_part1;
    logic [63:0] digest_part2;
    logic [63:0] digest_part3;
  } sha_out_t;

  // one 512-bit block for the compression core; byte 0 sits in the top bits
  typedef struct packed {
    logic                last;
    logic [BLK_BITS-1:0] data;
  } sha_blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sha_qstat_t;

  typedef enum logic [1:0] {
    FS_COLLECT,
    FS_PAD,
    FS_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_ADD
  } core_state_t;

endpackage

// File: rtl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Collects message bytes into a block buffer, counts the bit length and
// builds the padding blocks at message end; hands blocks to the queue.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sha_in_t    in_data,
  input  sha_qstat_t qstat,
  output logic       push,
  output sha_blk_t   push_blk
);

  front_state_t        state_r, state_nxt;
  logic [BLK_BITS-1:0] buf_r, buf_nxt;
  logic [5:0]          fill_r;
  logic [63:0]         bits_r;
  logic [BLK_BITS-1:0] pad_blk;
  logic                in_acc;
  logic                msg_done;

  assign in_acc = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_COLLECT: begin
        if (in_acc && in_data.end_of_message) state_nxt = FS_PAD;
      end
      FS_PAD: begin
        if (!qstat.full) state_nxt = (fill_r > PAD_LIMIT) ? FS_LEN : FS_COLLECT;
      end
      FS_LEN: begin
        if (!qstat.full) state_nxt = FS_COLLECT;
      end
      default: state_nxt = FS_COLLECT;
    endcase
  end

  // buffer with this beat's byte merged in, and the padded block
  always_comb begin
    for (int i = 0; i < BLK_BYTES; i++) begin
      buf_nxt[8*(BLK_BYTES-1-i) +: 8] = (6'(i) == fill_r) ? in_data.msg_byte
                                                          : buf_r[8*(BLK_BYTES-1-i) +: 8];
      if (6'(i) < fill_r) begin
        pad_blk[8*(BLK_BYTES-1-i) +: 8] = buf_r[8*(BLK_BYTES-1-i) +: 8];
      end else if (6'(i) == fill_r) begin
        pad_blk[8*(BLK_BYTES-1-i) +: 8] = PAD_MARK;
      end else begin
        pad_blk[8*(BLK_BYTES-1-i) +: 8] = 8'h00;
      end
    end
    if (fill_r <= PAD_LIMIT) pad_blk[63:0] = bits_r;
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    push          = 1'b0;
    push_blk.last = 1'b0;
    push_blk.data = buf_nxt;
    msg_done      = 1'b0;
    case (state_r)
      FS_COLLECT: begin
        in_ready = !qstat.full;
        push     = in_acc && in_data.byte_valid && (fill_r == FILL_LAST);
      end
      FS_PAD: begin
        push          = !qstat.full;
        push_blk.data = pad_blk;
        push_blk.last = (fill_r <= PAD_LIMIT);
        msg_done      = push && (fill_r <= PAD_LIMIT);
      end
      FS_LEN: begin
        push          = !qstat.full;
        push_blk.data = {{(BLK_BITS-64){1'b0}}, bits_r};
        push_blk.last = 1'b1;
        msg_done      = push;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_COLLECT;
      fill_r  <= '0;
      bits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_data.byte_valid) begin
        fill_r <= fill_r + 6'd1;
        bits_r <= bits_r + 64'd8;
      end
      if (msg_done) begin
        fill_r <= '0;
        bits_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.byte_valid) buf_r <= buf_nxt;
  end

endmodule

// File: rtl/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue
// Short block queue between the byte collector and the compression core.
// ----------------------------------------------------------------------------
module sha_queue import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sha_blk_t   push_blk,
  input  logic       pop,
  output sha_blk_t   pop_blk,
  output sha_qstat_t qstat
);

  sha_blk_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r;
  logic [Q_AW-1:0] rd_r;
  logic [Q_CW-1:0] count_r;

  assign pop_blk     = mem_r[rd_r];
  assign qstat.full  = (count_r == Q_CW'(Q_DEPTH));
  assign qstat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_blk;
  end

endmodule

// File: rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// SHA-256 compression: one round per cycle over a 16-word schedule window,
// chaining update and the digest output register.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sha_qstat_t qstat,
  input  sha_blk_t   pop_blk,
  output logic       pop,
  output logic       ld_digest,
  output logic       out_valid,
  input  logic       out_ready,
  output sha_out_t   out_data
);

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  core_state_t state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  round_r;
  logic        last_r;
  logic        out_valid_r;
  sha_out_t    out_data_r;
  logic        slot_free;
  logic [31:0] t1, t2, ch, maj, w_new;
  logic [31:0] sum [8];

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (!qstat.empty) state_nxt = CS_ROUND;
      end
      CS_ROUND: begin
        if (round_r == ROUND_LAST) state_nxt = CS_ADD;
      end
      CS_ADD: begin
        if (!last_r || slot_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    ld_digest = 1'b0;
    case (state_r)
      CS_IDLE:  pop = !qstat.empty;
      CS_ROUND: pop = 1'b0;
      CS_ADD:   ld_digest = last_r && slot_free;
      default:  pop = 1'b0;
    endcase
  end

  // round and schedule datapath
  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + bsig1(v_r[4]) + ch + K_TAB[round_r] + w_r[0];
    t2    = bsig0(v_r[0]) + maj;
    w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
    for (int i = 0; i < 8; i++) sum[i] = h_r[i] + v_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
      round_r     <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= IV_TAB[i];
    end else begin
      state_r <= state_nxt;
      if (ld_digest)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == CS_ROUND) round_r <= round_r + 6'd1;
      if (state_r == CS_ADD) begin
        // fold the block into the chain; a finished message restarts from IV
        if (!last_r) begin
          for (int i = 0; i < 8; i++) h_r[i] <= sum[i];
        end else if (slot_free) begin
          for (int i = 0; i < 8; i++) h_r[i] <= IV_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      last_r <= pop_blk.last;
      for (int j = 0; j < 16; j++) w_r[j] <= pop_blk.data[32*(15-j) +: 32];
      for (int i = 0; i < 8; i++)  v_r[i] <= h_r[i];
    end else if (state_r == CS_ROUND) begin
      for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (ld_digest) begin
      out_data_r.digest_part0 <= {sum[0], sum[1]};
      out_data_r.digest_part1 <= {sum[2], sum[3]};
      out_data_r.digest_part2 <= {sum[4], sum[5]};
      out_data_r.digest_part3 <= {sum[6], sum[7]};
    end
  end

endmodule

// File: rtl/sha256_hash.sv
// Message end: padding adds one or two blocks, each taken through a fetch,
//   64 rounds and a chain add before the digest, plus queue wait.
// Throughput: one beat per cycle while collecting and the two-block queue has
//   room; the one-round-per-cycle core sets the sustained rate.
// Reset: synchronous active-low rst_n restores the initial hash values and
//   empties the queue; the block buffer holds no reset value.
// ----------------------------------------------------------------------------
// sha256_hash
// SHA-256 over a byte stream: byte collector, block queue, compression core.
// ----------------------------------------------------------------------------
module sha256_hash import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sha_out_t out_data
);

  sha_qstat_t qstat;
  logic       push;
  logic       pop;
  logic       ld_digest;
  sha_blk_t   push_blk;
  sha_blk_t   pop_blk;

  sha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push),
    .push_blk (push_blk)
  );

  sha_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_blk (push_blk),
    .pop      (pop),
    .pop_blk  (pop_blk),
    .qstat    (qstat)
  );

  sha_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .pop_blk   (pop_blk),
    .pop       (pop),
    .ld_digest (ld_digest),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // never push a block into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full) else $error("block pushed into full queue");

  // never fetch from an empty queue
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("block fetched from empty queue");

  // a new digest never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ld_digest |-> (!out_valid || out_ready)) else $error("digest overrun");

  // a loaded digest shows up as valid on the next cycle
  a_digest_shown: assert property (@(posedge clk) disable iff (!rst_n)
    ld_digest |=> out_valid) else $error("digest not presented");

endmodule
